// File: hw/rtl/lp_pkg.sv
package lp_pkg;

   localparam int IDX_W  = 6;
   localparam int DATA_W = 32;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic signed [DATA_W-1:0] elem_type;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PART = 1'b1;

   typedef struct packed {
      logic     kind;
      idx_type  load_index;
      elem_type load_value;
      idx_type  range_start;
      idx_type  range_stop;
      idx_type  pivot_position;
   } req_type;

   typedef struct packed {
      idx_type  out_index;
      elem_type out_value;
      idx_type  pivot_final;
      logic     bad_request;
      logic     last;
   } rsp_type;

   // Control word fields.
   typedef enum logic [2:0] {RD_NONE, RD_PIV, RD_STOP, RD_I, RD_SLOT} rd_src_type;
   typedef enum logic [2:0] {WA_NONE, WA_PIV, WA_STOP, WA_I, WA_SLOT} wr_addr_type;
   typedef enum logic [1:0] {WD_RD, WD_PVAL, WD_TMP} wr_data_type;
   typedef enum logic [1:0] {PTR_HOLD, PTR_START, PTR_INC} ptr_op_type;
   typedef enum logic [1:0] {OUT_NONE, OUT_ELEM, OUT_ERR} out_op_type;
   typedef enum logic [2:0] {
      C_NEXT, C_ALWAYS, C_I_EQ_STOP, C_I_NE_STOP, C_NOT_LESS, C_BAD
   } cond_type;

   typedef logic [4:0] step_type;

   localparam step_type ST_IDLE  = 5'd0;
   localparam step_type ST_CHECK = 5'd1;
   localparam step_type ST_S0    = 5'd2;
   localparam step_type ST_S1    = 5'd3;
   localparam step_type ST_S2    = 5'd4;
   localparam step_type ST_S3    = 5'd5;
   localparam step_type ST_L0    = 5'd6;
   localparam step_type ST_L1    = 5'd7;
   localparam step_type ST_L2    = 5'd8;
   localparam step_type ST_L3    = 5'd9;
   localparam step_type ST_LSKIP = 5'd10;
   localparam step_type ST_F0    = 5'd11;
   localparam step_type ST_F1    = 5'd12;
   localparam step_type ST_F2    = 5'd13;
   localparam step_type ST_F3    = 5'd14;
   localparam step_type ST_E0    = 5'd15;
   localparam step_type ST_E1    = 5'd16;
   localparam step_type ST_DONE  = 5'd17;
   localparam step_type ST_ERR   = 5'd18;

   typedef struct packed {
      logic        wait_req;
      rd_src_type  rd_src;
      wr_addr_type wr_addr;
      wr_data_type wr_data;
      logic        ld_pval;
      logic        ld_tmp;
      ptr_op_type  i_op;
      ptr_op_type  slot_op;
      out_op_type  out_op;
      cond_type    cond;
      step_type    target;
   } ctl_type;

   typedef struct packed {
      logic bad;
      logic i_eq_stop;
      logic not_less;
      logic out_busy;
   } stat_type;

   localparam ctl_type CTL_NOP = '{
      wait_req: 1'b0, rd_src: RD_NONE, wr_addr: WA_NONE, wr_data: WD_RD,
      ld_pval: 1'b0, ld_tmp: 1'b0, i_op: PTR_HOLD, slot_op: PTR_HOLD,
      out_op: OUT_NONE, cond: C_NEXT, target: ST_IDLE
   };

   // Microprogram ROM. Read data issued in one step is visible in the next.
   function automatic ctl_type ucode(step_type s);
      ctl_type c;
      c = CTL_NOP;
      unique case (s)
         ST_IDLE:  c.wait_req = 1'b1;
         ST_CHECK: begin
            c.cond = C_BAD;
            c.target = ST_ERR;
         end
         ST_S0:    c.rd_src = RD_PIV;
         ST_S1: begin
            c.rd_src = RD_STOP;
            c.ld_pval = 1'b1;
         end
         ST_S2: begin
            c.wr_addr = WA_PIV;
            c.wr_data = WD_RD;
         end
         ST_S3: begin
            c.wr_addr = WA_STOP;
            c.wr_data = WD_PVAL;
            c.i_op = PTR_START;
            c.slot_op = PTR_START;
         end
         ST_L0: begin
            c.rd_src = RD_I;
            c.cond = C_I_EQ_STOP;
            c.target = ST_F0;
         end
         ST_L1: begin
            c.rd_src = RD_SLOT;
            c.ld_tmp = 1'b1;
            c.cond = C_NOT_LESS;
            c.target = ST_LSKIP;
         end
         ST_L2: begin
            c.wr_addr = WA_I;
            c.wr_data = WD_RD;
         end
         ST_L3: begin
            c.wr_addr = WA_SLOT;
            c.wr_data = WD_TMP;
            c.i_op = PTR_INC;
            c.slot_op = PTR_INC;
            c.cond = C_ALWAYS;
            c.target = ST_L0;
         end
         ST_LSKIP: begin
            c.i_op = PTR_INC;
            c.cond = C_ALWAYS;
            c.target = ST_L0;
         end
         ST_F0:    c.rd_src = RD_SLOT;
         ST_F1: begin
            c.rd_src = RD_STOP;
            c.ld_tmp = 1'b1;
         end
         ST_F2: begin
            c.wr_addr = WA_SLOT;
            c.wr_data = WD_RD;
         end
         ST_F3: begin
            c.wr_addr = WA_STOP;
            c.wr_data = WD_TMP;
            c.i_op = PTR_START;
         end
         ST_E0:    c.rd_src = RD_I;
         ST_E1: begin
            c.out_op = OUT_ELEM;
            c.i_op = PTR_INC;
            c.cond = C_I_NE_STOP;
            c.target = ST_E0;
         end
         ST_DONE: begin
            c.cond = C_ALWAYS;
            c.target = ST_IDLE;
         end
         ST_ERR: begin
            c.out_op = OUT_ERR;
            c.cond = C_ALWAYS;
            c.target = ST_IDLE;
         end
         default: begin
            c.cond = C_ALWAYS;
            c.target = ST_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/lp_ram.sv
module lp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lp_seq.sv
module lp_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  logic             req_kind,
   input  lp_pkg::stat_type stat,
   output lp_pkg::ctl_type  ctl,
   output logic             idle
);

   lp_pkg::step_type upc_ff, upc_in;
   lp_pkg::ctl_type  cw;
   logic             stall;
   logic             take;

   assign cw    = lp_pkg::ucode(upc_ff);
   // A result step waits while the output register still holds an unsent result.
   assign stall = (cw.out_op != lp_pkg::OUT_NONE) && stat.out_busy;
   assign ctl   = stall ? lp_pkg::CTL_NOP : cw;
   assign idle  = cw.wait_req;

   always_comb begin
      case (cw.cond)
         lp_pkg::C_ALWAYS:    take = 1'b1;
         lp_pkg::C_I_EQ_STOP: take = stat.i_eq_stop;
         lp_pkg::C_I_NE_STOP: take = !stat.i_eq_stop;
         lp_pkg::C_NOT_LESS:  take = stat.not_less;
         lp_pkg::C_BAD:       take = stat.bad;
         default:             take = 1'b0;
      endcase
   end

   always_comb begin
      upc_in = upc_ff;
      if (cw.wait_req) begin
         if (req_fire && (req_kind == lp_pkg::KIND_PART)) begin
            upc_in = lp_pkg::ST_CHECK;
         end
      end else if (!stall) begin
         upc_in = take ? cw.target : upc_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= lp_pkg::ST_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: hw/rtl/lp_dpath.sv
module lp_dpath #(
   parameter int STORE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  lp_pkg::req_type  req,
   input  lp_pkg::ctl_type  ctl,
   output lp_pkg::stat_type stat,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output lp_pkg::rsp_type  rsp
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int IW = lp_pkg::IDX_W;
   localparam logic [IW:0] DEPTH_CMP = (IW + 1)'(STORE_DEPTH);

   logic [AW-1:0]    start_ff, stop_ff, piv_ff, i_ff, slot_ff;
   logic [AW-1:0]    i_in, slot_in;
   logic             bad_ff, bad_in;
   lp_pkg::elem_type pval_ff, tmp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lp_pkg::rsp_type  rsp_ff, rsp_in;

   logic                     load_wr;
   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [lp_pkg::DATA_W-1:0] wr_data, rd_data;

   lp_ram #(
      .WIDTH(lp_pkg::DATA_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Loads beyond the store are dropped.
   assign load_wr = req_fire && (req.kind == lp_pkg::KIND_LOAD) &&
                    ({1'b0, req.load_index} < DEPTH_CMP);

   always_comb begin
      bad_in = (req.range_start > req.range_stop) ||
               ({1'b0, req.range_stop} >= DEPTH_CMP) ||
               (req.pivot_position < req.range_start) ||
               (req.pivot_position > req.range_stop);
   end

   always_comb begin
      case (ctl.rd_src)
         lp_pkg::RD_PIV:  rd_addr = piv_ff;
         lp_pkg::RD_STOP: rd_addr = stop_ff;
         lp_pkg::RD_I:    rd_addr = i_ff;
         lp_pkg::RD_SLOT: rd_addr = slot_ff;
         default:         rd_addr = i_ff;
      endcase
      rd_en = (ctl.rd_src != lp_pkg::RD_NONE);
   end

   always_comb begin
      wr_en = 1'b1;
      case (ctl.wr_addr)
         lp_pkg::WA_PIV:  wr_addr = piv_ff;
         lp_pkg::WA_STOP: wr_addr = stop_ff;
         lp_pkg::WA_I:    wr_addr = i_ff;
         lp_pkg::WA_SLOT: wr_addr = slot_ff;
         default: begin
            wr_addr = AW'(req.load_index);
            wr_en   = load_wr;
         end
      endcase
      case (ctl.wr_data)
         lp_pkg::WD_PVAL: wr_data = pval_ff;
         lp_pkg::WD_TMP:  wr_data = tmp_ff;
         default:         wr_data = (ctl.wr_addr == lp_pkg::WA_NONE) ? req.load_value : rd_data;
      endcase
   end

   always_comb begin
      case (ctl.i_op)
         lp_pkg::PTR_START: i_in = start_ff;
         lp_pkg::PTR_INC:   i_in = i_ff + AW'(1);
         default:           i_in = i_ff;
      endcase
      case (ctl.slot_op)
         lp_pkg::PTR_START: slot_in = start_ff;
         lp_pkg::PTR_INC:   slot_in = slot_ff + AW'(1);
         default:           slot_in = slot_ff;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (ctl.out_op)
         lp_pkg::OUT_ELEM: begin
            rsp_valid_in       = 1'b1;
            rsp_in.out_index   = IW'(i_ff);
            rsp_in.out_value   = $signed(rd_data);
            rsp_in.pivot_final = IW'(slot_ff);
            rsp_in.bad_request = 1'b0;
            rsp_in.last        = (i_ff == stop_ff);
         end
         lp_pkg::OUT_ERR: begin
            rsp_valid_in       = 1'b1;
            rsp_in.out_index   = '0;
            rsp_in.out_value   = '0;
            rsp_in.pivot_final = '0;
            rsp_in.bad_request = 1'b1;
            rsp_in.last        = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req.kind == lp_pkg::KIND_PART)) begin
         start_ff <= AW'(req.range_start);
         stop_ff  <= AW'(req.range_stop);
         piv_ff   <= AW'(req.pivot_position);
         bad_ff   <= bad_in;
      end
      i_ff    <= i_in;
      slot_ff <= slot_in;
      if (ctl.ld_pval) begin
         pval_ff <= $signed(rd_data);
      end
      if (ctl.ld_tmp) begin
         tmp_ff <= $signed(rd_data);
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.bad       = bad_ff;
   assign stat.i_eq_stop = (i_ff == stop_ff);
   assign stat.not_less  = !($signed(rd_data) < pval_ff);
   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: hw/rtl/lomuto_partition.sv
// Lomuto partition engine over a store of STORE_DEPTH signed 32-bit elements. A load request
// writes one element and returns nothing; loads past the store are dropped.
// A partition request swaps the pivot to the end of the region, moves every element smaller
// than the pivot forward, places the pivot, and then returns the region one element per
// response in ascending index order, each carrying the pivot's final index, the last one
// marked. An invalid region or pivot returns one error response and leaves the store alone.
// A microcoded sequencer drives one single-port-read store, so every element move costs a
// read and a write step; a partition takes longer the more elements move, and longer still
// while the response side stalls. One request is in flight at a time.
// Entries that are read must have been loaded first.
module lomuto_partition #(
   parameter int STORE_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  lp_pkg::req_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output lp_pkg::rsp_type rsp_payload
);

   lp_pkg::ctl_type  ctl;
   lp_pkg::stat_type stat;
   logic             idle;
   logic             req_fire;

   assign req_ready = idle;
   assign req_fire  = req_valid && req_ready;

   lp_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_fire(req_fire),
      .req_kind(req_payload.kind),
      .stat    (stat),
      .ctl     (ctl),
      .idle    (idle)
   );

   lp_dpath #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req      (req_payload),
      .ctl      (ctl),
      .stat     (stat),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_payload)
   );

endmodule

// File: tb/lomuto_partition_checker.sv
`timescale 1ns / 100ps

module lomuto_partition_checker #(
   parameter int DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  lp_pkg::req_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  lp_pkg::rsp_type rsp_payload,
   output int              mismatches,
   output int              words_due,
   output int              words_checked
);
   import lp_pkg::*;

   elem_type elems [DEPTH];
   rsp_type  region_words [$];

   initial begin
      mismatches = 0;
      words_due = 0;
      words_checked = 0;
   end

   // Applies one accepted request to the local copy of the store and queues the
   // responses it should produce.
   function automatic void apply_request(input req_type r);
      rsp_type  w;
      elem_type pval;
      elem_type t;
      int       slot;
      if (r.kind == KIND_LOAD) begin
         if (int'(r.load_index) < DEPTH) elems[r.load_index] = r.load_value;
         return;
      end
      w = '0;
      if (r.range_start > r.range_stop || int'(r.range_stop) >= DEPTH ||
          r.pivot_position < r.range_start || r.pivot_position > r.range_stop) begin
         w.bad_request = 1'b1;
         w.last = 1'b1;
         region_words.push_back(w);
         return;
      end
      pval = elems[r.pivot_position];
      elems[r.pivot_position] = elems[r.range_stop];
      elems[r.range_stop] = pval;
      slot = r.range_start;
      for (int i = r.range_start; i < r.range_stop; i++) begin
         if (elems[i] < pval) begin
            t = elems[slot];
            elems[slot] = elems[i];
            elems[i] = t;
            slot++;
         end
      end
      t = elems[slot];
      elems[slot] = elems[r.range_stop];
      elems[r.range_stop] = t;
      for (int i = r.range_start; i <= r.range_stop; i++) begin
         w.out_index = idx_type'(i);
         w.out_value = elems[i];
         w.pivot_final = idx_type'(slot);
         w.bad_request = 1'b0;
         w.last = (i == r.range_stop);
         region_words.push_back(w);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         region_words.delete();
         foreach (elems[i]) elems[i] = '0;
      end else begin
         if (req_valid && req_ready) apply_request(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (region_words.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, got %h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               want = region_words.pop_front();
               check_field("out_index", want.out_index, rsp_payload.out_index);
               check_field("out_value", want.out_value, rsp_payload.out_value);
               check_field("pivot_final", want.pivot_final, rsp_payload.pivot_final);
               check_field("bad_request", want.bad_request, rsp_payload.bad_request);
               check_field("last", want.last, rsp_payload.last);
               words_checked++;
            end
         end
      end
      words_due = region_words.size();
   end

endmodule

// File: tb/tb_lomuto_partition.sv
`timescale 1ns / 100ps

module tb_lomuto_partition;
   import lp_pkg::*;

   localparam elem_type ELEM_MIN = 32'sh8000_0000;
   localparam elem_type ELEM_MAX = 32'sh7fff_ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   int mismatches;
   int words_due;
   int words_checked;

   bit        calm = 1'b0;
   bit        rand_phase = 1'b0;
   bit [63:0] loaded = '0;
   int        n_loads = 0;
   int        n_parts = 0;
   int        n_bad = 0;

   lomuto_partition dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   lomuto_partition_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .mismatches    (mismatches),
      .words_due     (words_due),
      .words_checked (words_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("lomuto_partition verification failed");
      $finish;
   end

   // Response side: short random stalls, one long hold once random traffic is
   // flowing so that the engine backs up into the request channel.
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      forever begin
         if (rand_phase && !held && rsp_valid) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic offer(input req_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_payload <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Fields that a request kind does not use still carry random bits.
   function automatic req_type random_req();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   task automatic load(input int idx, input elem_type val);
      req_type r;
      r = random_req();
      r.kind = KIND_LOAD;
      r.load_index = idx_type'(idx);
      r.load_value = val;
      loaded[idx] = 1'b1;
      n_loads++;
      offer(r);
   endtask

   task automatic partition(input int s, input int e, input int p);
      req_type r;
      r = random_req();
      r.kind = KIND_PART;
      r.range_start = idx_type'(s);
      r.range_stop = idx_type'(e);
      r.pivot_position = idx_type'(p);
      if (s > e || p < s || p > e) n_bad++;
      else n_parts++;
      offer(r);
   endtask

   // The first edge lets the checker register a request accepted in this step.
   task automatic wait_drained(output bit ok);
      int n;
      n = 0;
      @(posedge clock);
      while (words_due != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      ok = (words_due == 0);
   endtask

   initial begin : stimulus
      bit       ok;
      int       pick;
      int       idx;
      int       s;
      int       e;
      elem_type v;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      load(0, ELEM_MIN);
      load(1, ELEM_MAX);
      load(2, 0);
      load(3, -1);
      load(4, 7);
      load(5, 7);
      load(63, 5);
      load(62, ELEM_MIN);
      partition(0, 5, 4);      // pivot with an equal twin
      partition(0, 5, 0);
      partition(0, 5, 1);
      partition(3, 3, 3);      // single-element region
      partition(62, 63, 63);
      partition(62, 63, 62);
      partition(5, 2, 3);      // start beyond stop
      partition(1, 4, 0);      // pivot below the region
      partition(1, 4, 5);      // pivot above the region
      partition(63, 0, 63);
      partition(0, 5, 5);
      partition(2, 4, 2);

      rand_phase = 1'b1;
      for (int k = 0; k < 330; k++) begin
         if (k == 150) begin
            req_valid <= 1'b0;
            wait_drained(ok);
         end
         calm = (k >= 290);
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            idx = $urandom_range(0, 63);
            if (!(&loaded) && $urandom_range(0, 1) == 1) begin
               while (loaded[idx]) idx = (idx + 1) % 64;
            end
            case ($urandom_range(0, 9))
               0: v = ELEM_MIN;
               1: v = ELEM_MAX;
               2, 3, 4: v = elem_type'(int'($urandom_range(0, 8)) - 4);
               default: v = elem_type'($urandom);
            endcase
            load(idx, v);
         end else if (pick < 90) begin
            if (&loaded && $urandom_range(0, 24) == 0) begin
               s = 0;
               e = 63;
            end else begin
               // Only regions made entirely of loaded entries may be partitioned.
               do s = $urandom_range(0, 63); while (!loaded[s]);
               e = s;
               while (e < 63 && loaded[e + 1]) e++;
               if ($urandom_range(0, 15) != 0)
                  e = s + $urandom_range(0, (e - s < 7) ? e - s : 7);
            end
            partition(s, e, $urandom_range(s, e));
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  s = $urandom_range(1, 63);
                  partition(s, $urandom_range(0, s - 1), $urandom_range(0, 63));
               end
               1: begin
                  s = $urandom_range(1, 63);
                  partition(s, $urandom_range(s, 63), $urandom_range(0, s - 1));
               end
               default: begin
                  e = $urandom_range(0, 62);
                  partition($urandom_range(0, e), e, $urandom_range(e + 1, 63));
               end
            endcase
         end
      end

      req_valid <= 1'b0;
      wait_drained(ok);
      if (ok) repeat (20) @(posedge clock);
      if (!ok) begin
         $display("lomuto_partition verification failed");
      end else begin
         $display("Run covered %0d loads, %0d partitions and %0d malformed regions;",
                  n_loads, n_parts, n_bad);
         $display("%0d responses were checked against the prediction.", words_checked);
         if (mismatches == 0 && words_due == 0) begin
            $display("lomuto_partition verification clean");
         end else begin
            $display("lomuto_partition verification failed");
         end
      end
      $finish;
   end

endmodule
